@@ hdl/gcd_lcm_unit_defines.svh @@
// Assertion macros shared by the gcd/lcm RTL.
// Each expects clk and rst_n in scope.
`ifndef GCD_LCM_UNIT_DEFINES_SVH
`define GCD_LCM_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define GLU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define GLU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/glu_pkg.sv @@
package glu_pkg;

  localparam int DATA_W            = 32;
  localparam int PROD_W            = 64;
  localparam int OPERAND_WIDTH_DEF = 32;

  typedef struct packed {
    logic [DATA_W-1:0] operand_a;
    logic [DATA_W-1:0] operand_b;
  } glu_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] divisor_result;
    logic [PROD_W-1:0] multiple_result;
  } glu_out_t;

  typedef enum logic {
    GLU_OP_DIV,
    GLU_OP_MUL
  } glu_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EUCLID,
    S_MOD,
    S_QUO,
    S_MUL,
    S_OUT
  } glu_state_t;

  typedef struct packed {
    logic    start;
    glu_op_t op;
  } glu_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } glu_sts_t;

endpackage

@@ hdl/gcd_lcm_unit.sv @@
// Channel | Ports                           | Item
// --------+---------------------------------+----------------------------------------------
// input   | in_valid, in_stall, in_data     | operand_a, operand_b (32b each)
// result  | out_valid, out_stall, out_data  | divisor_result (32b), multiple_result (64b)
//
// Sequence: an item with a zero operand goes straight to the result; else it takes
//   k Euclid remainder steps (at most 46 at W = OPERAND_WIDTH = 32), a quotient and a
//   product. A new item is accepted only once the last result is taken. Remainders,
//   quotient and product share one bit-serial divide/multiply unit, one bit a cycle.
// Reset: synchronous, active low; clears the sequencer and the unit control.
// Stalls: in_stall is high until the result is taken; a stalled result holds.
`include "gcd_lcm_unit_defines.svh"

module gcd_lcm_unit #(
  parameter int OPERAND_WIDTH = glu_pkg::OPERAND_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  glu_pkg::glu_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output glu_pkg::glu_out_t out_data
);
  import glu_pkg::*;

  localparam int W = OPERAND_WIDTH;

  glu_state_t        state_r, state_nxt;
  logic [W-1:0]      a_r, a_nxt;
  logic [W-1:0]      b_r, b_nxt;
  logic [W-1:0]      x_r, x_nxt;
  logic [W-1:0]      y_r, y_nxt;
  logic [W-1:0]      gcd_r, gcd_nxt;
  logic [2*W-1:0]    lcm_r, lcm_nxt;

  logic [W-1:0]      in_a;
  logic [W-1:0]      in_b;

  glu_ctl_t          u_ctl;
  glu_sts_t          u_sts;
  logic [W-1:0]      u_opa;
  logic [W-1:0]      u_opb;
  logic [W-1:0]      u_hi;
  logic [W-1:0]      u_lo;

  // Only the low W bits of each operand take part.
  assign in_a = in_data.operand_a[W-1:0];
  assign in_b = in_data.operand_b[W-1:0];

  glu_shared_unit #(
    .W (W)
  ) u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (u_ctl),
    .opa   (u_opa),
    .opb   (u_opb),
    .sts   (u_sts),
    .hi    (u_hi),
    .lo    (u_lo)
  );

  // Sequencer: for nonzero operands, Euclid on (x, y) with the unit's remainder, then a / gcd,
  // then (a / gcd) * b.
  always_comb begin
    state_nxt    = state_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    gcd_nxt      = gcd_r;
    lcm_nxt      = lcm_r;
    u_ctl.start  = 1'b0;
    u_ctl.op     = GLU_OP_DIV;
    u_opa        = x_r;
    u_opb        = y_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          a_nxt = in_a;
          b_nxt = in_b;
          if (in_a == '0) begin
            // zero operand: gcd is the other one, lcm is zero
            gcd_nxt   = in_b;
            lcm_nxt   = '0;
            state_nxt = S_OUT;
          end else if (in_b == '0) begin
            gcd_nxt   = in_a;
            lcm_nxt   = '0;
            state_nxt = S_OUT;
          end else begin
            x_nxt     = in_a;
            y_nxt     = in_b;
            state_nxt = S_EUCLID;
          end
        end
      end
      S_EUCLID: begin
        u_ctl.start = 1'b1;
        u_ctl.op    = GLU_OP_DIV;
        if (y_r == '0) begin
          // x holds the divisor: divide a by it next
          gcd_nxt   = x_r;
          u_opa     = a_r;
          u_opb     = x_r;
          state_nxt = S_QUO;
        end else begin
          u_opa     = x_r;
          u_opb     = y_r;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (u_sts.done) begin
          x_nxt     = y_r;
          y_nxt     = u_hi;
          state_nxt = S_EUCLID;
        end
      end
      S_QUO: begin
        if (u_sts.done) begin
          u_ctl.start = 1'b1;
          u_ctl.op    = GLU_OP_MUL;
          u_opa       = u_lo;
          u_opb       = b_r;
          state_nxt   = S_MUL;
        end
      end
      S_MUL: begin
        if (u_sts.done) begin
          lcm_nxt   = {u_hi, u_lo};
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // hold the result until it is taken
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    gcd_r <= gcd_nxt;
    lcm_r <= lcm_nxt;
  end

  assign in_stall                 = (state_r != S_IDLE);
  assign out_valid                = (state_r == S_OUT);
  assign out_data.divisor_result  = DATA_W'(gcd_r);
  assign out_data.multiple_result = PROD_W'(lcm_r);

  `GLU_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, state_r != S_IDLE,
                   "item accepted but sequencer stayed idle")
  `GLU_ASSERT_NEXT(a_mod_return, state_r == S_MOD && u_sts.done, state_r == S_EUCLID,
                   "remainder step did not return to Euclid check")
  `GLU_ASSERT_NOW(a_zero_gcd, state_r == S_OUT && gcd_r == '0, lcm_r == '0,
                  "zero divisor with nonzero multiple")

endmodule

@@ hdl/glu_shared_unit.sv @@
`include "gcd_lcm_unit_defines.svh"

// Bit-serial divide / multiply unit, one step per cycle over W steps.
// Divide: lo = opa / opb, hi = opa % opb.  Multiply: {hi, lo} = opa * opb.
module glu_shared_unit #(
  parameter int W = glu_pkg::OPERAND_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  glu_pkg::glu_ctl_t ctl,
  input  logic [W-1:0]      opa,
  input  logic [W-1:0]      opb,
  output glu_pkg::glu_sts_t sts,
  output logic [W-1:0]      hi,
  output logic [W-1:0]      lo
);
  import glu_pkg::*;

  localparam int CNT_W = $clog2(W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  glu_op_t           op_r, op_nxt;
  logic [W-1:0]      hi_r, hi_nxt;
  logic [W-1:0]      lo_r, lo_nxt;
  logic [W-1:0]      opb_r, opb_nxt;

  logic [W+1:0]      add_a;
  logic [W+1:0]      add_b;
  logic [W+1:0]      sum;
  logic              last;

  assign last = (cnt_r == CNT_W'(W - 1));

  // Shared adder: subtract the divisor, or add the gated multiplicand.
  always_comb begin
    if (op_r == GLU_OP_DIV) begin
      add_a = {1'b0, hi_r, lo_r[W-1]};
      add_b = ~{2'b00, opb_r};
    end else begin
      add_a = {2'b00, hi_r};
      add_b = {2'b00, (lo_r[0] ? opb_r : {W{1'b0}})};
    end
    sum = add_a + add_b + (W+2)'(op_r == GLU_OP_DIV);
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    op_nxt   = op_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    opb_nxt  = opb_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      op_nxt   = ctl.op;
      hi_nxt   = '0;
      lo_nxt   = opa;
      opb_nxt  = opb;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
      if (op_r == GLU_OP_DIV) begin
        // restoring step: keep the difference when it did not go negative
        if (!sum[W+1]) begin
          hi_nxt = sum[W-1:0];
          lo_nxt = {lo_r[W-2:0], 1'b1};
        end else begin
          hi_nxt = {hi_r[W-2:0], lo_r[W-1]};
          lo_nxt = {lo_r[W-2:0], 1'b0};
        end
      end else begin
        hi_nxt = sum[W:1];
        lo_nxt = {sum[0], lo_r[W-1:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= GLU_OP_DIV;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      op_r   <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_r  <= hi_nxt;
    lo_r  <= lo_nxt;
    opb_r <= opb_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign hi       = hi_r;
  assign lo       = lo_r;

  `GLU_ASSERT_NOW(a_start_idle, ctl.start, !busy_r, "start while unit busy")
  `GLU_ASSERT_NOW(a_done_idle, done_r, !busy_r, "done raised while still busy")
  `GLU_ASSERT_NEXT(a_last_done, busy_r && last && !ctl.start, done_r,
                   "final step not followed by done")

endmodule
